// ----- sv/wasw_pkg.sv -----
// Shared constants, codes and types of the windowed-average switching weight block.
`timescale 1ns / 1ps
package wasw_pkg;
   localparam int ATOMS      = 1024;
   localparam int HIST       = 128;
   localparam int ATOM_W     = $clog2(ATOMS);
   localparam int SLOT_W     = $clog2(HIST);
   localparam int SMP_AW     = ATOM_W + SLOT_W;
   localparam int SAMPLE_W   = 32;
   localparam int SUM_W      = 39;
   localparam int FILL_W     = 8;
   localparam int WEIGHT_W   = 17;
   localparam int DIV_STAGES = SUM_W;
   localparam int MIDQ_DEPTH = 4;
   localparam int MIDQ_PW    = $clog2(MIDQ_DEPTH);
   localparam int MIDQ_CW    = MIDQ_PW + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);
   localparam logic [FILL_W-1:0]   LEN_MIN = FILL_W'(2);
   localparam logic [FILL_W-1:0]   LEN_MAX = FILL_W'(HIST);

   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NON_GROUP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 3'd4;

   typedef struct packed {
      logic fix;
      logic precise;
      logic fast;
      logic ignore;
   } flags_type;

   typedef struct packed {
      flags_type             flags;
      logic [SUM_W-1:0]      sum;
      logic [FILL_W-1:0]     fill;
   } work_type;

   typedef struct packed {
      flags_type             flags;
      logic [SAMPLE_W-1:0]   avg;
   } avg_type;

   typedef struct packed {
      logic [31:0]           thresh_low;
      logic [31:0]           thresh_high;
      logic [31:0]           inverse_width;
      logic [WEIGHT_W-1:0]   non_group;
      logic [FILL_W-1:0]     window_length;
   } cfg_type;
endpackage

// ----- sv/wasw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wasw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/wasw_front.sv -----
// Front end: accepts items, steps the ring slot and fill count, updates window and sum for fix-group items.
`timescale 1ns / 1ps
module wasw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  wasw_pkg::cfg_type             cfg,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [wasw_pkg::ATOM_W-1:0]   req_atom_index,
   input  logic [wasw_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          req_step_start,
   input  logic                          req_in_fix_group,
   input  logic                          req_in_precise_group,
   input  logic                          req_in_fast_group,
   input  logic                          req_in_ignore_group,
   input  logic [wasw_pkg::MIDQ_CW-1:0]  midq_count,
   output logic                          midq_push,
   output wasw_pkg::work_type            midq_data
);
   import wasw_pkg::*;

   logic                 accept;
   logic [FILL_W-1:0]    len;
   logic [SLOT_W-1:0]    ring_ff, ring_in, slot_in;
   logic [FILL_W-1:0]    fill_ff, fill_in, item_fill;
   logic                 clr_ff;
   logic [SMP_AW-1:0]    clr_addr_ff;

   logic                 b_valid_ff;
   flags_type            b_flags_ff;
   logic [ATOM_W-1:0]    b_atom_ff;
   logic [SLOT_W-1:0]    b_slot_ff;
   logic [SAMPLE_W-1:0]  b_smp_ff;
   logic [FILL_W-1:0]    b_fill_ff;
   logic                 b_fwd_sum_ff, b_fwd_smp_ff;
   logic [SUM_W-1:0]     b_fwd_sum_val_ff;
   logic [SAMPLE_W-1:0]  b_fwd_smp_val_ff;

   logic [SAMPLE_W-1:0]  smp_rd, old_smp;
   logic [SUM_W-1:0]     sum_rd, old_sum, new_sum;
   logic                 b_write;

   always_comb begin
      if (cfg.window_length < LEN_MIN) begin
         len = LEN_MIN;
      end else if (cfg.window_length > LEN_MAX) begin
         len = LEN_MAX;
      end else begin
         len = cfg.window_length;
      end
   end

   assign ring_in = ((FILL_W'(ring_ff) + FILL_W'(1)) >= len) ? '0 : ring_ff + SLOT_W'(1);
   assign fill_in = (({1'b0, fill_ff} + 9'd1) > {1'b0, len}) ? len : fill_ff + FILL_W'(1);
   assign slot_in   = req_step_start ? ring_in : ring_ff;
   assign item_fill = req_step_start ? fill_in : fill_ff;

   // back stage never stalls, so leave room for it in the queue
   assign req_full = clr_ff ||
      ((4'(midq_count) + 4'(b_valid_ff)) >= 4'(MIDQ_DEPTH));
   assign accept   = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff     <= SLOT_W'(HIST - 1);
         fill_ff     <= '0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         b_valid_ff  <= 1'b0;
      end else begin
         if (accept && req_step_start) begin
            ring_ff <= ring_in;
            fill_ff <= fill_in;
         end
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + SMP_AW'(1);
            if (&clr_addr_ff) begin
               clr_ff <= 1'b0;
            end
         end
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_flags_ff       <= '{fix: req_in_fix_group, precise: req_in_precise_group,
                               fast: req_in_fast_group, ignore: req_in_ignore_group};
         b_atom_ff        <= req_atom_index;
         b_slot_ff        <= slot_in;
         b_smp_ff         <= req_sample;
         b_fill_ff        <= item_fill;
         // the RAM read misses the write made by the item just ahead
         b_fwd_sum_ff     <= b_write && (b_atom_ff == req_atom_index);
         b_fwd_sum_val_ff <= new_sum;
         b_fwd_smp_ff     <= b_write && (b_atom_ff == req_atom_index) &&
                             (b_slot_ff == slot_in);
         b_fwd_smp_val_ff <= b_smp_ff;
      end
   end

   assign b_write = b_valid_ff && b_flags_ff.fix;
   assign old_sum = b_fwd_sum_ff ? b_fwd_sum_val_ff : sum_rd;
   assign old_smp = b_fwd_smp_ff ? b_fwd_smp_val_ff : smp_rd;
   assign new_sum = old_sum - SUM_W'(old_smp) + SUM_W'(b_smp_ff);

   wasw_ram #(.WIDTH(SAMPLE_W), .DEPTH(ATOMS * HIST)) u_window (
      .clock (clock),
      .we    (clr_ff || b_write),
      .waddr (clr_ff ? clr_addr_ff : {b_atom_ff, b_slot_ff}),
      .wdata (clr_ff ? '0 : b_smp_ff),
      .raddr ({req_atom_index, slot_in}),
      .rdata (smp_rd)
   );

   wasw_ram #(.WIDTH(SUM_W), .DEPTH(ATOMS)) u_sum (
      .clock (clock),
      .we    (clr_ff || b_write),
      .waddr (clr_ff ? clr_addr_ff[ATOM_W-1:0] : b_atom_ff),
      .wdata (clr_ff ? '0 : new_sum),
      .raddr (req_atom_index),
      .rdata (sum_rd)
   );

   assign midq_push = b_valid_ff;
   assign midq_data = '{flags: b_flags_ff, sum: new_sum, fill: b_fill_ff};
endmodule

// ----- sv/wasw_midq.sv -----
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module wasw_midq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  wasw_pkg::work_type           push_data,
   input  logic                         pop,
   output logic                         empty,
   output wasw_pkg::work_type           head,
   output logic [wasw_pkg::MIDQ_CW-1:0] count
);
   import wasw_pkg::*;

   work_type             entry_ff [MIDQ_DEPTH];
   logic [MIDQ_PW-1:0]   wr_ff, rd_ff;
   logic [MIDQ_CW-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + MIDQ_PW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + MIDQ_PW'(1);
         end
         count_ff <= count_ff + MIDQ_CW'(push) - MIDQ_CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ff];
   assign count = count_ff;
endmodule

// ----- sv/wasw_div.sv -----
// Pipelined restoring divider: window sum over fill count, one quotient bit a stage.
`timescale 1ns / 1ps
module wasw_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  wasw_pkg::work_type in_work,
   output logic               out_valid,
   output wasw_pkg::avg_type  out_avg
);
   import wasw_pkg::*;

   logic [DIV_STAGES-1:0] v_ff;
   logic [FILL_W-1:0]     rem_ff   [DIV_STAGES];
   logic [SUM_W-1:0]      num_ff   [DIV_STAGES];
   logic [FILL_W-1:0]     dsr_ff   [DIV_STAGES];
   flags_type             flags_ff [DIV_STAGES];

   logic [FILL_W-1:0]     src_rem  [DIV_STAGES];
   logic [SUM_W-1:0]      src_num  [DIV_STAGES];
   logic [FILL_W-1:0]     src_dsr  [DIV_STAGES];
   logic [FILL_W:0]       trial    [DIV_STAGES];
   logic                  qbit     [DIV_STAGES];
   logic [FILL_W-1:0]     rem_in   [DIV_STAGES];
   logic [SUM_W-1:0]      num_in   [DIV_STAGES];
   logic [SUM_W-1:0]      quo;

   always_comb begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (i == 0) begin
            src_rem[i] = '0;
            src_num[i] = in_work.sum;
            src_dsr[i] = (in_work.fill == '0) ? FILL_W'(1) : in_work.fill;
         end else begin
            src_rem[i] = rem_ff[i-1];
            src_num[i] = num_ff[i-1];
            src_dsr[i] = dsr_ff[i-1];
         end
         trial[i]  = {src_rem[i], src_num[i][SUM_W-1]};
         qbit[i]   = trial[i] >= {1'b0, src_dsr[i]};
         rem_in[i] = qbit[i] ? FILL_W'(trial[i] - {1'b0, src_dsr[i]}) : trial[i][FILL_W-1:0];
         num_in[i] = {src_num[i][SUM_W-2:0], qbit[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i]   <= rem_in[i];
            num_ff[i]   <= num_in[i];
            dsr_ff[i]   <= src_dsr[i];
            flags_ff[i] <= (i == 0) ? in_work.flags : flags_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   assign quo       = num_ff[DIV_STAGES-1];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_avg   = '{flags: flags_ff[DIV_STAGES-1],
                        avg: (|quo[SUM_W-1:SAMPLE_W]) ? '1 : quo[SAMPLE_W-1:0]};
endmodule

// ----- sv/wasw_weight.sv -----
// Switching polynomial pipeline, weight selection and the result queue.
`timescale 1ns / 1ps
module wasw_weight (
   input  logic                          clock,
   input  logic                          reset,
   input  wasw_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   input  wasw_pkg::avg_type             in_avg,
   output logic                          advance,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [wasw_pkg::WEIGHT_W-1:0] rsp_weight,
   output logic [wasw_pkg::SAMPLE_W-1:0] rsp_average
);
   import wasw_pkg::*;

   logic [3:0]           v_ff;
   flags_type            flags_ff [4];
   logic [SAMPLE_W-1:0]  avg_ff   [4];
   logic                 le_ff    [4];
   logic                 ge_ff    [4];
   logic [63:0]          prod1_ff;
   logic [WEIGHT_W-1:0]  t2_t_ff, t3_t_ff, t3_t2_ff, t4_t3_ff;
   logic signed [22:0]   t4_p_ff;

   logic [WEIGHT_W-1:0]  t_sat;
   logic [33:0]          sq, cube;
   logic [22:0]          pos, neg;
   logic signed [40:0]   prod5;
   logic [WEIGHT_W-1:0]  s_val, poly_w, ngv, weight_in;

   localparam int OQ_DEPTH = 2;
   logic [WEIGHT_W-1:0]  oq_w_ff [OQ_DEPTH];
   logic [SAMPLE_W-1:0]  oq_a_ff [OQ_DEPTH];
   logic                 oq_wr_ff, oq_rd_ff;
   logic [1:0]           oq_cnt_ff;
   logic                 pop_fire, push_fire;

   assign pop_fire  = rsp_pop && !rsp_empty;
   assign advance   = (oq_cnt_ff < 2'(OQ_DEPTH)) || pop_fire;
   assign push_fire = advance && v_ff[3];

   assign t_sat = (prod1_ff[63:16] > 48'(ONE_Q16)) ? ONE_Q16 : prod1_ff[32:16];
   assign sq    = 34'(t2_t_ff) * 34'(t2_t_ff);
   assign cube  = 34'(t3_t2_ff) * 34'(t3_t_ff);
   assign pos   = 23'(t3_t2_ff) * 23'd6 + 23'd655360;
   assign neg   = 23'(t3_t_ff) * 23'd15;
   assign prod5 = 41'($signed({1'b0, t4_t3_ff})) * 41'(t4_p_ff);

   always_comb begin
      if (prod5 < 0) begin
         s_val = '0;
      end else if (prod5[40:16] > 25'(ONE_Q16)) begin
         s_val = ONE_Q16;
      end else begin
         s_val = prod5[32:16];
      end
   end

   assign poly_w = ONE_Q16 - s_val;
   assign ngv    = (cfg.non_group > ONE_Q16) ? ONE_Q16 : cfg.non_group;

   always_comb begin
      if (!flags_ff[3].fix || flags_ff[3].ignore) begin
         weight_in = ngv;
      end else begin
         weight_in = poly_w;
      end
      if (flags_ff[3].fix) begin
         if (flags_ff[3].precise) begin
            weight_in = '0;
         end else if (flags_ff[3].fast) begin
            weight_in = ONE_Q16;
         end else if (!flags_ff[3].ignore && le_ff[3]) begin
            weight_in = ONE_Q16;
         end else if (!flags_ff[3].ignore && ge_ff[3]) begin
            weight_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         if (advance) begin
            v_ff <= {v_ff[2:0], in_valid};
         end
         if (push_fire) begin
            oq_wr_ff <= ~oq_wr_ff;
         end
         if (pop_fire) begin
            oq_rd_ff <= ~oq_rd_ff;
         end
         oq_cnt_ff <= oq_cnt_ff + 2'(push_fire) - 2'(pop_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff[0] <= in_avg.flags;
         avg_ff[0]   <= in_avg.avg;
         le_ff[0]    <= in_avg.avg <= cfg.thresh_low;
         ge_ff[0]    <= in_avg.avg >= cfg.thresh_high;
         prod1_ff    <= 64'(in_avg.avg - cfg.thresh_low) * 64'(cfg.inverse_width);
         for (int i = 1; i < 4; i++) begin
            flags_ff[i] <= flags_ff[i-1];
            avg_ff[i]   <= avg_ff[i-1];
            le_ff[i]    <= le_ff[i-1];
            ge_ff[i]    <= ge_ff[i-1];
         end
         t2_t_ff  <= t_sat;
         t3_t_ff  <= t2_t_ff;
         t3_t2_ff <= sq[32:16];
         t4_t3_ff <= cube[32:16];
         t4_p_ff  <= $signed(pos - neg);
      end
      if (push_fire) begin
         oq_w_ff[oq_wr_ff] <= weight_in;
         oq_a_ff[oq_wr_ff] <= flags_ff[3].fix ? avg_ff[3] : '0;
      end
   end

   assign rsp_empty   = (oq_cnt_ff == '0);
   assign rsp_weight  = oq_w_ff[oq_rd_ff];
   assign rsp_average = oq_a_ff[oq_rd_ff];
endmodule

// ----- sv/windowed_average_switching_weight.sv -----
// Top level: configuration registers and the front end, divider and weight back end.
//
//  channel  ports                        transfer when
//  input    req_push / req_full          req_push && !req_full
//  result   rsp_pop / rsp_empty          rsp_pop && !rsp_empty
//  config   csr_valid / csr_ready        csr_valid && csr_ready (ready always high)
//
// One item per cycle sustained while the result side keeps up; a result passes
// through the front stage (window/sum read-modify-write), the mid queue,
// 39 divider stages and four polynomial stages into a two-entry result queue.
// After reset a clearing pass zeroes all 131072 window entries and the sum RAM;
// req_full stays high meanwhile. A stalled result side backs the pipeline up
// into the mid queue, which then raises req_full.
`timescale 1ns / 1ps
module windowed_average_switching_weight (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [wasw_pkg::ATOM_W-1:0]     req_atom_index,
   input  logic [wasw_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                            req_step_start,
   input  logic                            req_in_fix_group,
   input  logic                            req_in_precise_group,
   input  logic                            req_in_fast_group,
   input  logic                            req_in_ignore_group,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [wasw_pkg::WEIGHT_W-1:0]   rsp_weight,
   output logic [wasw_pkg::SAMPLE_W-1:0]   rsp_average,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wasw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wasw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wasw_pkg::*;

   cfg_type             cfg_ff;
   logic                midq_push, midq_empty, advance, div_valid;
   work_type            midq_in, midq_head;
   logic [MIDQ_CW-1:0]  midq_count;
   avg_type             div_avg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thresh_low    <= '0;
         cfg_ff.thresh_high   <= 32'd65536;
         cfg_ff.inverse_width <= 32'd65536;
         cfg_ff.non_group     <= ONE_Q16;
         cfg_ff.window_length <= FILL_W'(100);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESH_LOW:    cfg_ff.thresh_low    <= csr_wdata;
            CSR_THRESH_HIGH:   cfg_ff.thresh_high   <= csr_wdata;
            CSR_INVERSE_WIDTH: cfg_ff.inverse_width <= csr_wdata;
            CSR_NON_GROUP:     cfg_ff.non_group     <= csr_wdata[WEIGHT_W-1:0];
            CSR_WINDOW_LENGTH: cfg_ff.window_length <= csr_wdata[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   wasw_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_atom_index       (req_atom_index),
      .req_sample           (req_sample),
      .req_step_start       (req_step_start),
      .req_in_fix_group     (req_in_fix_group),
      .req_in_precise_group (req_in_precise_group),
      .req_in_fast_group    (req_in_fast_group),
      .req_in_ignore_group  (req_in_ignore_group),
      .midq_count           (midq_count),
      .midq_push            (midq_push),
      .midq_data            (midq_in)
   );

   wasw_midq u_midq (
      .clock     (clock),
      .reset     (reset),
      .push      (midq_push),
      .push_data (midq_in),
      .pop       (advance && !midq_empty),
      .empty     (midq_empty),
      .head      (midq_head),
      .count     (midq_count)
   );

   wasw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (!midq_empty),
      .in_work   (midq_head),
      .out_valid (div_valid),
      .out_avg   (div_avg)
   );

   wasw_weight u_weight (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (div_valid),
      .in_avg      (div_avg),
      .advance     (advance),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_weight  (rsp_weight),
      .rsp_average (rsp_average)
   );
endmodule

// ----- sv/wasw_checker.sv -----
// Port-level checks on the top level, attached by bind.
`timescale 1ns / 1ps
module wasw_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_full,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input logic [wasw_pkg::WEIGHT_W-1:0]   rsp_weight,
   input logic [wasw_pkg::SAMPLE_W-1:0]   rsp_average,
   input logic                            csr_valid,
   input logic                            csr_ready
);
   import wasw_pkg::*;

   // weight never exceeds one
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_weight <= ONE_Q16))
      else $error("weight above one");

   // a result not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_weight) &&
                                    $stable(rsp_average)))
      else $error("waiting result changed");

   // clearing pass holds off input after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> req_full)
      else $error("input open during clearing");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");
endmodule

bind windowed_average_switching_weight wasw_checker u_chk (.*);
